>>> sv/palette_lerp_color_map_assert.svh
// assertion macros for the palette lerp color map checker
// expects clk_i and rst_ni in the scope of each use
`ifndef PALETTE_LERP_COLOR_MAP_ASSERT_SVH
`define PALETTE_LERP_COLOR_MAP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define PLCM_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent ends
`define PLCM_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

>>> sv/plcm_pkg.sv
// package for the palette lerp color map: widths, palette depth, codes and types
// no dependencies
package plcm_pkg;

  localparam int unsigned INDEX_BITS    = 8;
  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned PAL_DEPTH     = (1 << INDEX_BITS) + 1;
  localparam int unsigned ADDR_W        = INDEX_BITS + 1;
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned CHAN_NUM      = 4;
  localparam int unsigned COLOR_W       = CHAN_W * CHAN_NUM;
  localparam int unsigned FRAC_ONE      = 1 << FRACTION_BITS;
  localparam int unsigned WEIGHT_W      = FRACTION_BITS + 1;
  localparam int unsigned PROD_W        = CHAN_W + WEIGHT_W;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_MAP   = 1'b1
  } func_e;

  typedef logic [COLOR_W-1:0]       color_t;
  typedef logic [FRACTION_BITS-1:0] frac_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  // per-stage advance enables handed to the datapath
  typedef struct packed {
    logic mul_en;
    logic out_en;
  } pipe_en_t;

endpackage

>>> sv/plcm_lerp.sv
// two-stage blend datapath: per-channel weight products, then sum and scale
// depends on plcm_pkg
module plcm_lerp (
  input  logic               clk_i,
  input  plcm_pkg::pipe_en_t en_i,
  input  plcm_pkg::color_t   color_lo_i,
  input  plcm_pkg::color_t   color_hi_i,
  input  plcm_pkg::frac_t    frac_i,
  output plcm_pkg::color_t   color_out_o
);

  logic [plcm_pkg::WEIGHT_W-1:0] weight_lo;
  logic [plcm_pkg::PROD_W-1:0]   prod_lo_d [plcm_pkg::CHAN_NUM];
  logic [plcm_pkg::PROD_W-1:0]   prod_hi_d [plcm_pkg::CHAN_NUM];
  logic [plcm_pkg::PROD_W-1:0]   prod_lo_q [plcm_pkg::CHAN_NUM];
  logic [plcm_pkg::PROD_W-1:0]   prod_hi_q [plcm_pkg::CHAN_NUM];
  logic [plcm_pkg::PROD_W-1:0]   sum_w     [plcm_pkg::CHAN_NUM];
  plcm_pkg::color_t              color_d;
  plcm_pkg::color_t              color_q;

  assign weight_lo = plcm_pkg::WEIGHT_W'(plcm_pkg::FRAC_ONE)
                   - plcm_pkg::WEIGHT_W'(frac_i);

  always_comb begin
    for (int ch = 0; ch < plcm_pkg::CHAN_NUM; ch++) begin
      prod_lo_d[ch] = plcm_pkg::PROD_W'(color_lo_i[ch*plcm_pkg::CHAN_W +: plcm_pkg::CHAN_W])
                    * plcm_pkg::PROD_W'(weight_lo);
      prod_hi_d[ch] = plcm_pkg::PROD_W'(color_hi_i[ch*plcm_pkg::CHAN_W +: plcm_pkg::CHAN_W])
                    * plcm_pkg::PROD_W'(frac_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      prod_lo_q <= prod_lo_d;
      prod_hi_q <= prod_hi_d;
    end
  end

  // sum stays below 2^16, so the scaled value fits a channel
  always_comb begin
    for (int ch = 0; ch < plcm_pkg::CHAN_NUM; ch++) begin
      sum_w[ch] = prod_lo_q[ch] + prod_hi_q[ch];
      color_d[ch*plcm_pkg::CHAN_W +: plcm_pkg::CHAN_W] =
        sum_w[ch][plcm_pkg::FRACTION_BITS +: plcm_pkg::CHAN_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.out_en) begin
      color_q <= color_d;
    end
  end

  assign color_out_o = color_q;

endmodule

>>> sv/palette_lerp_color_map.sv
// palette lerp color map top level: palette memory, pipeline control, blend datapath
// depends on plcm_pkg and plcm_lerp
//
//  channel | handshake         | payload
//  --------+-------------------+---------------------------------------------------
//  input   | valid_i / stall_o | func_i, entry_index_i, entry_color_i, pixel_value_i
//  output  | valid_o / stall_i | color_out_o
//
// one item per cycle unless stall_o is raised; a pixel passes each stage below in order before it reaches the output
// stages: palette read of both entries, weight multiply, sum and output register
// a palette write takes effect at its transfer edge and gives no output
// reset clears only the stage valid bits; the palette is undefined until written
// a stalled output holds; bubbles in the pipe still fill while the output is stalled
module palette_lerp_color_map (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic                     func_i,
  input  logic [8:0]               entry_index_i,
  input  logic [31:0]              entry_color_i,
  input  logic [15:0]              pixel_value_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic [31:0]              color_out_o
);

  plcm_pkg::color_t pal_mem [plcm_pkg::PAL_DEPTH];

  logic                           en1, en2, en3;
  logic                           accept;
  logic                           wr_en;
  plcm_pkg::addr_t                wr_addr;
  logic [plcm_pkg::INDEX_BITS-1:0] pix_idx;
  plcm_pkg::addr_t                rd_addr_lo, rd_addr_hi;
  plcm_pkg::color_t               rd_lo_q, rd_hi_q;
  plcm_pkg::frac_t                frac_q;
  logic                           v1_d;
  logic                           v1_q, v2_q, v3_q;
  plcm_pkg::pipe_en_t             pipe_en;

  // stage enables, back to front
  assign en3     = !v3_q || !stall_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;
  assign accept  = valid_i && en1;

  assign wr_en   = accept && (func_i == plcm_pkg::FUNC_WRITE)
                && (32'(entry_index_i) < plcm_pkg::PAL_DEPTH);
  assign wr_addr = plcm_pkg::ADDR_W'(entry_index_i);

  assign pix_idx    = plcm_pkg::INDEX_BITS'(pixel_value_i >> plcm_pkg::FRACTION_BITS);
  assign rd_addr_lo = plcm_pkg::ADDR_W'(pix_idx);
  assign rd_addr_hi = plcm_pkg::ADDR_W'(pix_idx) + plcm_pkg::ADDR_W'(1);

  assign v1_d = accept && (func_i == plcm_pkg::FUNC_MAP);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pal_mem[wr_addr] <= entry_color_i;
    end
    if (en1) begin
      rd_lo_q <= pal_mem[rd_addr_lo];
      rd_hi_q <= pal_mem[rd_addr_hi];
      frac_q  <= plcm_pkg::frac_t'(pixel_value_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= v1_d;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign pipe_en.mul_en = en2;
  assign pipe_en.out_en = en3;

  plcm_lerp u_lerp (
    .clk_i       (clk_i),
    .en_i        (pipe_en),
    .color_lo_i  (rd_lo_q),
    .color_hi_i  (rd_hi_q),
    .frac_i      (frac_q),
    .color_out_o (color_out_o)
  );

  assign valid_o = v3_q;

endmodule

>>> sv/plcm_checker.sv
// port-level checks for the palette lerp color map, bound to the top level
// depends on palette_lerp_color_map_assert.svh
`include "palette_lerp_color_map_assert.svh"

module plcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        func_i,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] color_out_o
);

  `PLCM_ASSERT_NEXT(a_out_valid_holds, valid_o && stall_i, valid_o, "output valid dropped under stall")
  `PLCM_ASSERT_NEXT(a_out_data_holds, valid_o && stall_i, $stable(color_out_o), "stalled color changed")
  `PLCM_ASSERT_NOW(a_stall_only_when_full, stall_o, valid_o && stall_i, "input stalled with room in pipe")
  `PLCM_ASSERT_NEXT(a_map_latency, (valid_i && !stall_o && func_i) ##1 !stall_i ##1 !stall_i, valid_o, "pixel missing after three cycles")

endmodule

bind palette_lerp_color_map plcm_checker u_plcm_checker (.*);
